>>> rtl/mesh_cell_sample_address_gen_top_assert.svh
// assertion macros used by the checker file
`ifndef MESH_CELL_SAMPLE_ADDRESS_GEN_TOP_ASSERT_SVH
`define MESH_CELL_SAMPLE_ADDRESS_GEN_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define MCSAG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define MCSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mcsag_pkg.sv
// shared types and constants of the mesh cell sample address generator
package mcsag_pkg;

	localparam int COORD_W   = 24;
	localparam int FRAC_W    = 8;
	localparam int PIX_W     = 14;
	localparam int ADDR_W    = 28;
	localparam int IDX_W     = 6;
	localparam int REG_W     = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [PIX_W-1:0] PIXEL_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ROW_STRIDE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] corner0_x;
		logic signed [COORD_W-1:0] corner0_y;
		logic signed [COORD_W-1:0] corner1_x;
		logic signed [COORD_W-1:0] corner1_y;
		logic signed [COORD_W-1:0] corner2_x;
		logic signed [COORD_W-1:0] corner2_y;
		logic signed [COORD_W-1:0] corner3_x;
		logic signed [COORD_W-1:0] corner3_y;
	} cell_t;

	typedef struct packed {
		logic [IDX_W-1:0]  sample_index;
		logic [PIX_W-1:0]  pixel_x;
		logic [PIX_W-1:0]  pixel_y;
		logic [ADDR_W-1:0] pixel_address;
		logic              last_sample;
	} sample_t;

endpackage

>>> rtl/mesh_cell_sample_address_gen_top.sv
// mesh cell sample address generator: bilinear walk over a warped cell, clamp, address
//
//  channel   signals                              direction  handshake
//  command   start, busy, corners                 in         start && !busy
//  result    result_valid, result                 out        strobe, one cycle, no hold-off
//  config    cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//            cfg_data
//
// one cell gives SAMPLES_PER_SIDE^2 results (64 at the default), one per clock
// busy drops in the cycle that issues a cell's last sample, so cells run back to
// back with no gap; the issue counter is the only limit on rate
// first result reaches the ports through the five registered stages s1 to s5 behind issue
// reset clears the issue counter and the stage valid bits and sets all three
// registers to 1; config writes are always taken (cfg_ready tied high)
// the result side has no stall, the pipeline advances every cycle
module mesh_cell_sample_address_gen_top #(
	parameter int SAMPLES_PER_SIDE = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  mcsag_pkg::cell_t                    corners,
	// result channel
	output logic                                result_valid,
	output mcsag_pkg::sample_t                  result,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mcsag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcsag_pkg::REG_W-1:0]         cfg_data
);

	// counter and weight widths
	localparam int IW   = $clog2(SAMPLES_PER_SIDE);
	localparam int CW   = IW + 1;
	localparam int AREA = SAMPLES_PER_SIDE * SAMPLES_PER_SIDE;
	localparam int L    = $clog2(AREA);
	localparam int WW   = L + 2;
	// product and sum widths, signed
	localparam int PRW  = mcsag_pkg::COORD_W + WW;
	localparam int SUMW = PRW + 2;
	// whole-pixel dividend: non-negative sum shifted by the fraction bits
	localparam int VW   = mcsag_pkg::COORD_W - 1 - mcsag_pkg::FRAC_W + L;
	// divide by AREA as multiply by ceil(2^KSH / AREA), exact for VW-bit values
	localparam int KSH  = VW + L;
	localparam int MW   = VW + 2;
	localparam int PW   = VW + MW;
	localparam logic [MW-1:0] MUL_K = MW'((2 ** KSH + AREA - 1) / AREA);

	localparam int PIX_W  = mcsag_pkg::PIX_W;
	localparam int ADDR_W = mcsag_pkg::ADDR_W;
	localparam int IDX_W  = mcsag_pkg::IDX_W;
	localparam int REG_W  = mcsag_pkg::REG_W;

	// clamp limit from an image size: zero size gives 0, oversize saturates
	function automatic logic [PIX_W-1:0] clamp_lim(input logic [REG_W-1:0] size);
		logic [REG_W-1:0] dec;
		dec = size - REG_W'(1);
		if (size == '0) begin
			return '0;
		end else if (dec > REG_W'(mcsag_pkg::PIXEL_MAX)) begin
			return mcsag_pkg::PIXEL_MAX;
		end else begin
			return dec[PIX_W-1:0];
		end
	endfunction

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [REG_W-1:0] width_q;
	logic [REG_W-1:0] height_q;
	logic [REG_W-1:0] stride_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= REG_W'(1);
			height_q <= REG_W'(1);
			stride_q <= REG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcsag_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				mcsag_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				mcsag_pkg::REG_ROW_STRIDE:   stride_q <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	logic [PIX_W-1:0] lim_x;
	logic [PIX_W-1:0] lim_y;

	always_comb begin
		lim_x = clamp_lim(width_q);
		lim_y = clamp_lim(height_q);
	end

	// ---------------------------------------------------------------
	// issue: holds the cell and walks row i, column j
	// ---------------------------------------------------------------
	mcsag_pkg::cell_t cell_q;
	logic [IW-1:0]    row_q;
	logic [IW-1:0]    col_q;
	logic             active_q;
	logic             last_issue;
	logic             accept;

	assign last_issue = active_q && (row_q == IW'(SAMPLES_PER_SIDE - 1))
		&& (col_q == IW'(SAMPLES_PER_SIDE - 1));
	// free again while the final sample goes out, so the next cell follows directly
	assign busy   = active_q && !last_issue;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			row_q    <= '0;
			col_q    <= '0;
		end else if (active_q) begin
			if (last_issue) begin
				active_q <= 1'b0;
			end
			if (col_q == IW'(SAMPLES_PER_SIDE - 1)) begin
				col_q <= '0;
				row_q <= row_q + IW'(1);
			end else begin
				col_q <= col_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q <= corners;
		end
	end

	// bilinear weights for the sample being issued
	logic [CW-1:0]          row_hi, row_lo, col_hi, col_lo;
	logic signed [WW-1:0]   wgt [4];
	logic signed [mcsag_pkg::COORD_W-1:0] cx [4];
	logic signed [mcsag_pkg::COORD_W-1:0] cy [4];

	always_comb begin
		row_lo = CW'(row_q);
		col_lo = CW'(col_q);
		row_hi = CW'(SAMPLES_PER_SIDE) - row_lo;
		col_hi = CW'(SAMPLES_PER_SIDE) - col_lo;
		wgt[0] = $signed({1'b0, (WW-1)'(row_hi) * (WW-1)'(col_hi)});
		wgt[1] = $signed({1'b0, (WW-1)'(row_hi) * (WW-1)'(col_lo)});
		wgt[2] = $signed({1'b0, (WW-1)'(row_lo) * (WW-1)'(col_hi)});
		wgt[3] = $signed({1'b0, (WW-1)'(row_lo) * (WW-1)'(col_lo)});
		cx[0] = cell_q.corner0_x;
		cy[0] = cell_q.corner0_y;
		cx[1] = cell_q.corner1_x;
		cy[1] = cell_q.corner1_y;
		cx[2] = cell_q.corner2_x;
		cy[2] = cell_q.corner2_y;
		cx[3] = cell_q.corner3_x;
		cy[3] = cell_q.corner3_y;
	end

	// ---------------------------------------------------------------
	// stage 1: weighted corner terms
	// ---------------------------------------------------------------
	logic                  vld_s1;
	logic signed [PRW-1:0] tx_s1 [4];
	logic signed [PRW-1:0] ty_s1 [4];
	logic [IDX_W-1:0]      idx_s1;
	logic                  last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			tx_s1[k] <= PRW'(cx[k]) * PRW'(wgt[k]);
			ty_s1[k] <= PRW'(cy[k]) * PRW'(wgt[k]);
		end
		idx_s1  <= IDX_W'(row_q) * IDX_W'(SAMPLES_PER_SIDE) + IDX_W'(col_q);
		last_s1 <= last_issue;
	end

	// ---------------------------------------------------------------
	// stage 2: blended Q.8 sums
	// ---------------------------------------------------------------
	logic                   vld_s2;
	logic signed [SUMW-1:0] sx_s2;
	logic signed [SUMW-1:0] sy_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic                   last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sx_s2   <= SUMW'(tx_s1[0]) + SUMW'(tx_s1[1]) + SUMW'(tx_s1[2]) + SUMW'(tx_s1[3]);
		sy_s2   <= SUMW'(ty_s1[0]) + SUMW'(ty_s1[1]) + SUMW'(ty_s1[2]) + SUMW'(ty_s1[3]);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
	end

	// ---------------------------------------------------------------
	// stage 3: whole pixels, floor of sum over area times 256
	// ---------------------------------------------------------------
	logic [PW-1:0] qx_full, qy_full;

	always_comb begin
		qx_full = (PW'(sx_s2[VW+mcsag_pkg::FRAC_W-1:mcsag_pkg::FRAC_W]) * PW'(MUL_K)) >> KSH;
		qy_full = (PW'(sy_s2[VW+mcsag_pkg::FRAC_W-1:mcsag_pkg::FRAC_W]) * PW'(MUL_K)) >> KSH;
	end

	logic             vld_s3;
	logic [VW-1:0]    qx_s3, qy_s3;
	logic             negx_s3, negy_s3;
	logic [IDX_W-1:0] idx_s3;
	logic             last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		qx_s3   <= qx_full[VW-1:0];
		qy_s3   <= qy_full[VW-1:0];
		negx_s3 <= sx_s2[SUMW-1];
		negy_s3 <= sy_s2[SUMW-1];
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
	end

	// ---------------------------------------------------------------
	// stage 4: clamp into the image, negative positions go to 0
	// ---------------------------------------------------------------
	logic             vld_s4;
	logic [PIX_W-1:0] px_s4, py_s4;
	logic [IDX_W-1:0] idx_s4;
	logic             last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (negx_s3) begin
			px_s4 <= '0;
		end else if (qx_s3 > VW'(lim_x)) begin
			px_s4 <= lim_x;
		end else begin
			px_s4 <= qx_s3[PIX_W-1:0];
		end
		if (negy_s3) begin
			py_s4 <= '0;
		end else if (qy_s3 > VW'(lim_y)) begin
			py_s4 <= lim_y;
		end else begin
			py_s4 <= qy_s3[PIX_W-1:0];
		end
		idx_s4  <= idx_s3;
		last_s4 <= last_s3;
	end

	// ---------------------------------------------------------------
	// stage 5: word address, wraps at the address width
	// ---------------------------------------------------------------
	logic               vld_s5;
	mcsag_pkg::sample_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_s5.sample_index  <= idx_s4;
		res_s5.pixel_x       <= px_s4;
		res_s5.pixel_y       <= py_s4;
		res_s5.pixel_address <= ADDR_W'(py_s4) * ADDR_W'(stride_q) + ADDR_W'(px_s4);
		res_s5.last_sample   <= last_s4;
	end

	assign result_valid = vld_s5;
	assign result       = res_s5;

endmodule

>>> rtl/mcsag_checker.sv
// port-level checks of the sample address generator, bound to the top level
`include "mesh_cell_sample_address_gen_top_assert.svh"

module mcsag_checker #(
	parameter int SAMPLES_PER_SIDE = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input mcsag_pkg::sample_t result
);

	localparam int IDX_W = mcsag_pkg::IDX_W;

	// last flag only on the final grid position
	`MCSAG_ASSERT_NOW(a_last_index, clk, arst_n, result_valid && result.last_sample, result.sample_index == IDX_W'(SAMPLES_PER_SIDE * SAMPLES_PER_SIDE - 1), "last sample at wrong index")

	// a run never breaks up, the next sample follows at once
	`MCSAG_ASSERT_NEXT(a_run_gapless, clk, arst_n, result_valid && !result.last_sample, result_valid, "gap inside a sample run")

	// indices count up by one inside a run
	`MCSAG_ASSERT_NEXT(a_index_step, clk, arst_n, result_valid && !result.last_sample, result.sample_index == IDX_W'($past(result.sample_index) + IDX_W'(1)), "sample index skipped")

	// an accepted cell keeps the command side busy
	`MCSAG_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy, "busy missing after accept")

endmodule

bind mesh_cell_sample_address_gen_top mcsag_checker #(
	.SAMPLES_PER_SIDE(SAMPLES_PER_SIDE)
) u_mcsag_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
